>>> rtl/core/ipt_pkg.sv
// shared types, constants and codes for the ip prefix trie lookup
package ipt_pkg;

	localparam int NODE_COUNT_DEF = 65536;
	localparam int ADDR_BITS_DEF  = 32;
	localparam int STEPS_W        = 6;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_WRITE  = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] ip_address;
		logic [15:0] node_index;
		logic [15:0] left_child;
		logic [15:0] right_child;
		logic [15:0] node_area;
		logic [15:0] node_location;
	} item_t;

	typedef struct packed {
		logic               found;
		logic [15:0]        area_code;
		logic [15:0]        location_code;
		logic [STEPS_W-1:0] steps;
	} result_t;

	typedef struct packed {
		logic [15:0] left_child;
		logic [15:0] right_child;
		logic [15:0] area;
		logic [15:0] location;
	} node_t;

	typedef struct packed {
		result_t acc;
		logic    stop;
	} step_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_WALK
	} state_t;

endpackage

>>> rtl/core/ip_prefix_trie_lookup.sv
// top level: node table writes and longest prefix lookups over a binary trie
// A write beat stores one node in the cycle it is accepted and leaves busy low, so writes can
// follow every cycle. A lookup keeps busy high from its acceptance while it reads the root and
// then one node per further level (up to ADDR_BITS levels below the root), since each level
// needs the previous node's child index from the single table read port. The result is on
// result, marked by result_valid for a single cycle, in the first cycle with busy low; a new
// item may be started in that same cycle. The receiver cannot stall results. Nodes have no
// reset value: a lookup must only reach nodes already written.
module ip_prefix_trie_lookup import ipt_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output result_t result,
	output logic    result_valid
);

	localparam int IDX_W = $clog2(NODE_COUNT);

	state_t           state_q, state_next;
	logic [31:0]      addr_q;
	result_t          acc_q;
	result_t          result_q;
	logic             result_valid_q;
	logic             accept;
	logic             wr_en;
	logic [31:0]      wr_idx_ext;
	node_t            wr_node;
	logic [IDX_W-1:0] rd_addr;
	node_t            rd_node;
	step_res_t        step;
	logic [IDX_W-1:0] next_idx;
	logic             walking;

	assign accept     = start && !busy;
	assign busy       = (state_q != ST_IDLE);
	assign walking    = (state_q == ST_ROOT) || (state_q == ST_WALK);
	assign wr_idx_ext = 32'(item.node_index);
	assign wr_en      = accept && (item.action == ACT_WRITE) && (wr_idx_ext < 32'(NODE_COUNT));
	assign wr_node    = '{left_child: item.left_child, right_child: item.right_child,
		area: item.node_area, location: item.node_location};
	assign rd_addr    = walking ? next_idx : '0;

	ipt_node_mem #(.NODE_COUNT(NODE_COUNT)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx_ext[IDX_W-1:0]),
		.wr_data (wr_node),
		.rd_addr (rd_addr),
		.rd_data (rd_node)
	);

	ipt_step #(.NODE_COUNT(NODE_COUNT), .ADDR_BITS(ADDR_BITS)) u_step (
		.node     (rd_node),
		.first    (state_q == ST_ROOT),
		.acc      (acc_q),
		.dir      (addr_q[ADDR_BITS-1]),
		.res      (step),
		.next_idx (next_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (item.action == ACT_LOOKUP)) begin
					state_next = ST_ROOT;
				end
			end
			ST_ROOT, ST_WALK: begin
				state_next = step.stop ? ST_IDLE : ST_WALK;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= walking && step.stop;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= item.ip_address;
		end else if (walking && !step.stop) begin
			addr_q <= addr_q << 1;
		end
		if (walking) begin
			acc_q <= step.acc;
		end
		if (walking && step.stop) begin
			result_q <= step.acc;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

`ifndef ASSERT_OFF
	a_result_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a lookup in progress");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !$past(result_valid))
		else $error("two results in consecutive cycles");

	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.steps <= STEPS_W'(ADDR_BITS)))
		else $error("step count beyond address width");

	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.action == ACT_LOOKUP)) |=> busy)
		else $error("lookup accepted without going busy");
`endif

endmodule

>>> rtl/core/ipt_node_mem.sv
// node table memory, one write port and one registered read port
module ipt_node_mem import ipt_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	localparam int IDX_W = $clog2(NODE_COUNT)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  node_t            wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output node_t            rd_data
);

	node_t mem [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/core/ipt_step.sv
// one trie level: code merge, child select and stop test
module ipt_step import ipt_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF,
	localparam int IDX_W = $clog2(NODE_COUNT)
) (
	input  node_t            node,
	input  logic             first,
	input  result_t          acc,
	input  logic             dir,
	output step_res_t        res,
	output logic [IDX_W-1:0] next_idx
);

	logic [15:0] child;
	logic [31:0] child_ext;
	result_t     merged;

	always_comb begin
		if (first) begin
			merged.found         = 1'b0;
			merged.area_code     = node.area;
			merged.location_code = node.location;
			merged.steps         = '0;
		end else begin
			merged.found         = acc.found | (node.area != '0);
			merged.area_code     = (node.area != '0) ? node.area : acc.area_code;
			merged.location_code = (node.location != '0) ? node.location : acc.location_code;
			merged.steps         = acc.steps + STEPS_W'(1);
		end
		child     = dir ? node.right_child : node.left_child;
		child_ext = 32'(child);
		res.acc   = merged;
		res.stop  = (child == '0) || (child_ext >= 32'(NODE_COUNT))
			|| (merged.steps == STEPS_W'(ADDR_BITS));
		next_idx  = child_ext[IDX_W-1:0];
	end

endmodule

>>> test/trie_lookup_checker.sv
`timescale 1ns / 1ps
// checker: mirrors node writes, predicts each lookup result and compares it with the block
module trie_lookup_checker import ipt_pkg::*; #(
	parameter int NODES  = NODE_COUNT_DEF,
	parameter int ADDR_W = ADDR_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  result_t result,
	input  logic    result_valid,
	output int      mismatches,
	output int      awaiting
);

	node_t   node_mem [NODES];
	result_t expected_lookups [$];
	int      fault_count = 0;

	function automatic result_t walk_trie(input logic [31:0] addr);
		result_t res;
		node_t   at;
		int      child;
		logic    halted;
		at                = node_mem[0];
		res.found         = 1'b0;
		res.area_code     = at.area;
		res.location_code = at.location;
		res.steps         = '0;
		halted            = 1'b0;
		for (int depth = 0; depth < ADDR_W; depth++) begin
			if (!halted) begin
				child = addr[ADDR_W - 1 - depth] ? at.right_child : at.left_child;
				if (child == 0 || child >= NODES) begin
					halted = 1'b1;
				end else begin
					at        = node_mem[child];
					res.steps = res.steps + STEPS_W'(1);
					if (at.area != 16'd0) begin
						res.found     = 1'b1;
						res.area_code = at.area;
					end
					if (at.location != 16'd0)
						res.location_code = at.location;
				end
			end
		end
		return res;
	endfunction

	task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
		fault_count++;
		$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (expected_lookups.size() == 0) begin
					fault_count++;
					$display("%0t ns: result with no lookup pending, expected none actual %p",
						$time, result);
				end else begin
					want = expected_lookups.pop_front();
					if (result.found !== want.found)
						flag("found", 64'(want.found), 64'(result.found));
					if (result.area_code !== want.area_code)
						flag("area_code", 64'(want.area_code), 64'(result.area_code));
					if (result.location_code !== want.location_code)
						flag("location_code", 64'(want.location_code),
							64'(result.location_code));
					if (result.steps !== want.steps)
						flag("steps", 64'(want.steps), 64'(result.steps));
				end
			end
			if (start && !busy) begin
				if (item.action == ACT_WRITE) begin
					if (item.node_index < NODES)
						node_mem[item.node_index] = '{item.left_child, item.right_child,
							item.node_area, item.node_location};
				end else begin
					expected_lookups.push_back(walk_trie(item.ip_address));
				end
			end
		end
		mismatches <= fault_count;
		awaiting   <= expected_lookups.size();
	end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, trie building and lookup stimulus, final verdict
module tb_top;
	import ipt_pkg::*;

	localparam int ITEM_TARGET = 1650;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	result_t result;
	logic    result_valid;
	int      mismatches;
	int      awaiting;

	int      beats_sent = 0;
	int      idle_pct   = 32;
	node_t   shadow [int];
	int      written [$];

	always #4 clk = ~clk;

	ip_prefix_trie_lookup dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.result       (result),
		.result_valid (result_valid)
	);

	trie_lookup_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.mismatches   (mismatches),
		.awaiting     (awaiting)
	);

	task automatic send_beat(input item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		beats_sent++;
		if (beats_sent == ITEM_TARGET / 3)
			idle_pct = 60;
		else if (beats_sent == 2 * ITEM_TARGET / 3)
			idle_pct = 0;
	endtask

	// child pointers only ever name nodes already written
	function automatic logic [15:0] pick_child();
		if (written.size() == 0 || $urandom_range(3) == 0)
			return 16'd0;
		return 16'(written[$urandom_range(written.size() - 1)]);
	endfunction

	function automatic logic [15:0] pick_code();
		case ($urandom_range(7))
			0, 1, 2, 3: return 16'd0;
			4:          return 16'hFFFF;
			default:    return 16'($urandom_range(65535, 1));
		endcase
	endfunction

	task automatic write_node(input int idx, input logic [15:0] lc, input logic [15:0] rc,
		input logic [15:0] area, input logic [15:0] loc);
		item_t it;
		it               = '0;
		it.action        = ACT_WRITE;
		it.ip_address    = $urandom();
		it.node_index    = 16'(idx);
		it.left_child    = lc;
		it.right_child   = rc;
		it.node_area     = area;
		it.node_location = loc;
		send_beat(it);
		if (!shadow.exists(idx))
			written.push_back(idx);
		shadow[idx] = '{lc, rc, area, loc};
	endtask

	task automatic lookup(input logic [31:0] addr);
		item_t it;
		it               = '0;
		it.action        = ACT_LOOKUP;
		it.ip_address    = addr;
		it.node_index    = 16'($urandom());
		it.left_child    = 16'($urandom());
		it.right_child   = 16'($urandom());
		it.node_area     = 16'($urandom());
		it.node_location = 16'($urandom());
		send_beat(it);
	endtask

	// writes a chain bottom-up along a random address, hooks it under the root, then probes it
	task automatic grow_path();
		logic [31:0] target;
		logic [31:0] mask;
		logic [15:0] chain [0:32];
		logic [15:0] toward;
		logic [15:0] other;
		logic        dir;
		node_t       root;
		int          len;
		int          pick;
		int          pre;
		target = $urandom();
		pick   = $urandom_range(19);
		if (pick == 0)
			len = $urandom_range(32, 21);
		else if (pick <= 5)
			len = $urandom_range(20, 7);
		else
			len = $urandom_range(6, 1);
		for (int k = 1; k <= len; k++)
			chain[k] = 16'($urandom_range(65535, 1));
		for (int k = len; k >= 1; k--) begin
			toward = (k < len) ? chain[k + 1] : pick_child();
			other  = pick_child();
			dir    = target[31 - (k % 32)];
			if (dir)
				write_node(chain[k], other, toward, pick_code(), pick_code());
			else
				write_node(chain[k], toward, other, pick_code(), pick_code());
		end
		root = shadow[0];
		if ($urandom_range(4) == 0) begin
			root.area     = pick_code();
			root.location = pick_code();
		end
		if (target[31])
			root.right_child = chain[1];
		else
			root.left_child = chain[1];
		write_node(0, root.left_child, root.right_child, root.area, root.location);
		repeat ($urandom_range(6, 1)) begin
			pre  = $urandom_range(1) ? 32 : $urandom_range(32);
			mask = ~32'h0 << (32 - pre);
			lookup((target & mask) | ($urandom() & ~mask));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// root alone, then a self loop down the zero side
		write_node(0, 16'd0, 16'd0, 16'h1234, 16'h5678);
		lookup(32'hFFFFFFFF);
		lookup(32'h00000000);
		write_node(65535, 16'd65535, 16'd0, 16'hFFFF, 16'hFFFF);
		write_node(0, 16'd65535, 16'd0, 16'd0, 16'd0);
		lookup(32'h00000000);
		lookup(32'h7FFFFFFF);
		lookup(32'hFFFFFFFF);
		// location only below root, full depth down the one side
		write_node(1, 16'd0, 16'd1, 16'd0, 16'h0001);
		write_node(0, 16'd65535, 16'd1, 16'hFFFF, 16'hFFFF);
		lookup(32'hFFFFFFFF);
		lookup(32'h80000000);
		// area deeper than location
		write_node(2, 16'd0, 16'd0, 16'h0005, 16'd0);
		write_node(1, 16'd2, 16'd1, 16'd0, 16'd0);
		lookup(32'hBFFFFFFF);
		lookup(32'hA0000000);
		lookup(32'h55555555);

		while (beats_sent < ITEM_TARGET) begin
			if ($urandom_range(3) != 0)
				grow_path();
			else if ($urandom_range(1))
				write_node($urandom_range(65535), pick_child(), pick_child(), pick_code(),
					pick_code());
			else
				lookup($urandom());
		end
		start <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
